[design/generational_handle_pool_macros.svh]
// Assertion macros used by the generational handle pool top level.
`ifndef GENERATIONAL_HANDLE_POOL_MACROS_SVH
`define GENERATIONAL_HANDLE_POOL_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define GHP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define GHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/ghp_pkg.sv]
// Types and constants shared by the generational handle pool modules.
package ghp_pkg;

  typedef enum logic [1:0] {
    MODE_CREATE  = 2'd0,
    MODE_UPDATE  = 2'd1,
    MODE_DESTROY = 2'd2,
    MODE_LOOKUP  = 2'd3
  } ghp_mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_STALE     = 2'd2,
    ST_FULL      = 2'd3
  } ghp_status_t;

  // Slots are scanned in groups of this many by the free slot finder.
  localparam int GROUP_SIZE = 8;

  typedef struct packed {
    ghp_mode_t   mode;
    logic [7:0]  handle_index;
    logic [15:0] handle_generation;
    logic [63:0] payload_in;
  } ghp_in_item_t;

  typedef struct packed {
    logic        ok;
    ghp_status_t status;
    logic [5:0]  index_out;
    logic [15:0] generation_out;
    logic [63:0] payload_out;
  } ghp_out_item_t;

  // Result of the free slot search.
  typedef struct packed {
    logic       found;
    logic [7:0] slot;
  } ghp_free_t;

endpackage

[design/ghp_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module ghp_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/ghp_free_finder.sv]
// Two-stage registered search for the lowest-numbered slot that is not alive.
module ghp_free_finder #(
  parameter int SLOT_COUNT = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [SLOT_COUNT-1:0] alive_i,
  output ghp_pkg::ghp_free_t    free_o
);
  import ghp_pkg::*;

  localparam int NG = (SLOT_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PW = NG * GROUP_SIZE;

  logic [PW-1:0] free_pad;
  logic [NG-1:0] grp_any_nxt;
  logic [NG-1:0] grp_any_r;
  logic [2:0]    grp_low_nxt [NG];
  logic [2:0]    grp_low_r   [NG];
  ghp_free_t     free_nxt;
  ghp_free_t     free_r;

  // Padding slots above the pool size read as taken.
  assign free_pad = PW'(~alive_i);

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_any_nxt[g] = 1'b0;
      grp_low_nxt[g] = 3'd0;
      for (int b = GROUP_SIZE - 1; b >= 0; b--) begin
        if (free_pad[g*GROUP_SIZE + b]) begin
          grp_any_nxt[g] = 1'b1;
          grp_low_nxt[g] = 3'(b);
        end
      end
    end
  end

  always_comb begin
    free_nxt = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        free_nxt.found = 1'b1;
        free_nxt.slot  = 8'(g * GROUP_SIZE + int'(grp_low_r[g]));
      end
    end
  end

  // Reset values match a pool with every slot free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_any_r <= '1;
      for (int g = 0; g < NG; g++) begin
        grp_low_r[g] <= 3'd0;
      end
      free_r <= '{found: 1'b1, slot: 8'd0};
    end else begin
      grp_any_r <= grp_any_nxt;
      for (int g = 0; g < NG; g++) begin
        grp_low_r[g] <= grp_low_nxt[g];
      end
      free_r <= free_nxt;
    end
  end

  assign free_o = free_r;

endmodule

[design/generational_handle_pool.sv]
// Generational handle pool top level: request sequencer, slot memory and free slot finder.
// Each item passes the address and execute states; the result is registered in the latter.
// A new item is accepted only once the last one is done, and a create or destroy that succeeds
// adds a settle state that lets the two-stage free slot finder see the new alive flags.
// Reset: alive flags and generation valid bits clear at once; no memory clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
module generational_handle_pool #(
  parameter int SLOT_COUNT   = 64,
  parameter int GEN_BITS     = 16,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  ghp_pkg::ghp_in_item_t  in_item,
  output logic                   out_valid,
  output ghp_pkg::ghp_out_item_t out_item
);
  import ghp_pkg::*;

  `include "generational_handle_pool_macros.svh"

  // Index width into the slot arrays, and the width used to compare generations.
  localparam int IW = $clog2(SLOT_COUNT);
  localparam int MW = GEN_BITS + PAYLOAD_BITS;
  localparam int CW = (GEN_BITS > 16) ? GEN_BITS : 16;

  // The sequencer walks each item through an address cycle, where the slot memory
  // is read, and an execute cycle, where the entry is checked, written back and the
  // result is registered. The settle cycle only waits for the free slot finder.
  typedef enum logic [1:0] {
    S_IDLE,
    S_ADDR,
    S_EXEC,
    S_SETTLE
  } state_t;

  state_t          state_r, state_nxt;
  ghp_in_item_t    req_r, req_nxt;
  logic [IW-1:0]   slot_r, slot_nxt;
  logic            full_r, full_nxt;
  logic            bad_r, bad_nxt;
  logic            gv_r, gv_nxt;
  logic [SLOT_COUNT-1:0] alive_r, alive_nxt;
  logic [SLOT_COUNT-1:0] gvalid_r, gvalid_nxt;
  logic            out_valid_r, out_valid_nxt;
  ghp_out_item_t   out_r, out_nxt;

  ghp_free_t       free;
  logic            ram_we;
  logic [MW-1:0]   ram_wdata;
  logic            ram_re;
  logic [IW-1:0]   ram_raddr;
  logic [MW-1:0]   ram_rdata;

  logic            in_range;
  logic [IW-1:0]   addr;
  logic [GEN_BITS-1:0]     gen_rd;
  logic [PAYLOAD_BITS-1:0] pay_rd;
  logic [GEN_BITS-1:0]     gen_inc;
  logic [GEN_BITS-1:0]     gen_new;
  logic                    gen_match;

  // Each memory word holds a slot's generation above its payload. A generation
  // that was never written reads as zero through its valid bit.
  ghp_ram #(
    .WIDTH (MW),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ghp_free_finder #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_free_finder (
    .clk    (clk),
    .rst_n  (rst_n),
    .alive_i(alive_r),
    .free_o (free)
  );

  // Handle checks on the captured request.
  assign in_range  = {1'b0, req_r.handle_index} < 9'(SLOT_COUNT);
  assign addr      = (req_r.mode == MODE_CREATE) ? free.slot[IW-1:0] :
                     (in_range ? req_r.handle_index[IW-1:0] : '0);

  // Fields of the entry read in the address cycle.
  assign gen_rd    = gv_r ? ram_rdata[MW-1:PAYLOAD_BITS] : '0;
  assign pay_rd    = ram_rdata[PAYLOAD_BITS-1:0];
  assign gen_match = CW'(gen_rd) == CW'(req_r.handle_generation);

  // The generation wraps from its maximum value to one, never to zero.
  assign gen_inc   = gen_rd + GEN_BITS'(1);
  assign gen_new   = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    slot_nxt      = slot_r;
    full_nxt      = full_r;
    bad_nxt       = bad_r;
    gv_nxt        = gv_r;
    alive_nxt     = alive_r;
    gvalid_nxt    = gvalid_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_re        = 1'b0;
    ram_raddr     = addr;
    ram_we        = 1'b0;
    ram_wdata     = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_item;
          state_nxt = S_ADDR;
        end
      end

      S_ADDR: begin
        // Read the addressed slot and register what the execute cycle needs.
        ram_re    = 1'b1;
        slot_nxt  = addr;
        gv_nxt    = gvalid_r[addr];
        full_nxt  = !free.found;
        bad_nxt   = !in_range || (req_r.handle_generation == 16'd0);
        state_nxt = S_EXEC;
      end

      S_EXEC: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '0;
        state_nxt     = S_IDLE;
        if (req_r.mode == MODE_CREATE) begin
          if (full_r) begin
            out_nxt.status = ST_FULL;
          end else begin
            ram_we               = 1'b1;
            ram_wdata            = {gen_new, req_r.payload_in[PAYLOAD_BITS-1:0]};
            alive_nxt[slot_r]    = 1'b1;
            gvalid_nxt[slot_r]   = 1'b1;
            out_nxt.ok           = 1'b1;
            out_nxt.status       = ST_OK;
            out_nxt.index_out    = 6'(slot_r);
            out_nxt.generation_out = 16'(gen_new);
            state_nxt            = S_SETTLE;
          end
        end else if (bad_r) begin
          out_nxt.status = ST_MALFORMED;
        end else if (!alive_r[slot_r] || !gen_match) begin
          out_nxt.status = ST_STALE;
        end else begin
          out_nxt.ok     = 1'b1;
          out_nxt.status = ST_OK;
          case (req_r.mode)
            MODE_UPDATE: begin
              ram_we    = 1'b1;
              ram_wdata = {gen_rd, req_r.payload_in[PAYLOAD_BITS-1:0]};
            end
            MODE_DESTROY: begin
              // The generation stays so that the next create of this slot advances it.
              ram_we            = 1'b1;
              ram_wdata         = {gen_rd, {PAYLOAD_BITS{1'b0}}};
              alive_nxt[slot_r] = 1'b0;
              state_nxt         = S_SETTLE;
            end
            MODE_LOOKUP: begin
              out_nxt.payload_out = 64'(pay_rd);
            end
            default: begin
              out_nxt = out_nxt;
            end
          endcase
        end
      end

      S_SETTLE: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      alive_r     <= '0;
      gvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      alive_r     <= alive_nxt;
      gvalid_r    <= gvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r  <= req_nxt;
    slot_r <= slot_nxt;
    full_r <= full_nxt;
    bad_r  <= bad_nxt;
    gv_r   <= gv_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // An accepted item is in flight for the next cycle and has no result yet.
  `GHP_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !out_valid, "accept did not hold busy")
  // Exactly one result per item: the result strobe is never raised back to back.
  `GHP_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe lasted two cycles")
  // The ok flag agrees with the status code.
  `GHP_ASSERT_NOW(a_ok_status, out_valid, out_item.ok == (out_item.status == ST_OK), "ok mismatch")
  // A failed request returns all data fields as zero.
  `GHP_ASSERT_NOW(a_fail_zero, out_valid && !out_item.ok, (out_item.index_out == 6'd0) && (out_item.generation_out == 16'd0) && (out_item.payload_out == 64'd0), "nonzero fields on failure")

endmodule

[verif/generational_handle_pool_tb.sv]
// Self-checking testbench for the generational handle pool: directed table, reuse sweep, random.
`timescale 1ns / 1ps

module generational_handle_pool_tb;
  import ghp_pkg::*;

  // The design is used with its default sizes, so the model below uses the same.
  localparam int SLOTS          = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_TAIL     = 4;
  localparam int SWEEP_PAIRS    = 16;
  localparam int RANDOM_ITEMS   = 360;
  localparam int MAX_REPORTS    = 10;

  // One row of the directed table. When typed is set, want holds the result
  // written out by hand; otherwise the pool model supplies the expectation.
  typedef struct {
    ghp_in_item_t  req;
    bit            typed;
    ghp_out_item_t want;
  } dir_row_t;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          start;
  logic          busy;
  ghp_in_item_t  in_item;
  logic          out_valid;
  ghp_out_item_t out_item;

  // Private copy of the pool contents, advanced once per accepted item.
  logic          pool_alive [SLOTS];
  logic [15:0]   pool_gen   [SLOTS];
  logic [63:0]   pool_word  [SLOTS];

  // Results that accepted items still owe, oldest first.
  ghp_out_item_t expected_results[$];
  dir_row_t      directed_rows[$];

  int error_count = 0;
  int idle_count  = 0;
  int burst_left  = 0;
  bit filling     = 1'b1;

  generational_handle_pool uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  function automatic ghp_in_item_t mk_req(ghp_mode_t m, int idx, int gen, logic [63:0] word);
    ghp_in_item_t r;
    r.mode              = m;
    r.handle_index      = 8'(idx);
    r.handle_generation = 16'(gen);
    r.payload_in        = word;
    return r;
  endfunction

  function automatic ghp_out_item_t mk_res(logic ok, ghp_status_t st, int idx, int gen,
                                           logic [63:0] word);
    ghp_out_item_t r;
    r.ok             = ok;
    r.status         = st;
    r.index_out      = 6'(idx);
    r.generation_out = 16'(gen);
    r.payload_out    = word;
    return r;
  endfunction

  function automatic void add_row(ghp_in_item_t req, bit typed, ghp_out_item_t want);
    dir_row_t row;
    row.req   = req;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  // Applies one request to the model pool and returns the result it must produce.
  // Create takes the lowest free slot and bumps its generation, stepping over zero.
  // The other modes validate the handle first: a zero generation or an index past
  // the pool is malformed, a dead slot or a different generation is stale.
  function automatic ghp_out_item_t predict_pool(ghp_in_item_t req);
    ghp_out_item_t res;
    ghp_status_t   st;
    logic [15:0]   g;
    int            s;
    res = '0;
    if (req.mode == MODE_CREATE) begin
      st = ST_FULL;
      for (s = 0; s < SLOTS; s++) begin
        if (st == ST_FULL && !pool_alive[s]) begin
          g = pool_gen[s] + 16'd1;
          if (g == 16'd0) begin
            g = 16'd1;
          end
          pool_gen[s]        = g;
          pool_word[s]       = req.payload_in;
          pool_alive[s]      = 1'b1;
          res.index_out      = 6'(s);
          res.generation_out = g;
          st                 = ST_OK;
        end
      end
    end else if (req.handle_generation == 16'd0 || req.handle_index >= SLOTS) begin
      st = ST_MALFORMED;
    end else if (!pool_alive[req.handle_index] ||
                 pool_gen[req.handle_index] != req.handle_generation) begin
      st = ST_STALE;
    end else begin
      st = ST_OK;
      case (req.mode)
        MODE_UPDATE: begin
          pool_word[req.handle_index] = req.payload_in;
        end
        MODE_DESTROY: begin
          pool_word[req.handle_index]  = '0;
          pool_alive[req.handle_index] = 1'b0;
        end
        default: begin
          res.payload_out = pool_word[req.handle_index];
        end
      endcase
    end
    res.ok     = (st == ST_OK);
    res.status = st;
    return res;
  endfunction

  function automatic int live_slots();
    int n;
    int s;
    n = 0;
    for (s = 0; s < SLOTS; s++) begin
      if (pool_alive[s]) n++;
    end
    return n;
  endfunction

  // Random traffic is mostly valid handles taken from the model pool, so that
  // updates, lookups and destroys actually land. The mix leans toward creates
  // while filling and toward destroys while draining, which walks the pool
  // between nearly empty and full. The rest is malformed or stale handles.
  function automatic ghp_in_item_t random_request();
    ghp_in_item_t req;
    int           live_list[$];
    int           dead_list[$];
    int           create_pct;
    int           destroy_pct;
    int           roll;
    int           pick;
    int           s;
    req.mode              = ghp_mode_t'($urandom_range(0, 3));
    req.handle_index      = 8'($urandom);
    req.handle_generation = 16'($urandom);
    req.payload_in        = {$urandom, $urandom};
    for (s = 0; s < SLOTS; s++) begin
      if (pool_alive[s]) live_list.push_back(s);
      else dead_list.push_back(s);
    end
    create_pct  = filling ? 55 : 10;
    destroy_pct = 55 - create_pct + 10;
    roll        = $urandom_range(0, 99);
    if (roll < create_pct) begin
      // The handle fields stay random: create must ignore them.
      req.mode = MODE_CREATE;
    end else if (roll < 88 && live_list.size() != 0) begin
      pick                  = live_list[$urandom_range(0, live_list.size() - 1)];
      req.handle_index      = 8'(pick);
      req.handle_generation = pool_gen[pick];
      if (roll < create_pct + destroy_pct) begin
        req.mode = MODE_DESTROY;
      end else if ($urandom_range(0, 1) == 0) begin
        req.mode = MODE_UPDATE;
      end else begin
        req.mode = MODE_LOOKUP;
      end
    end else begin
      case ($urandom_range(0, 4))
        0: begin
          req.handle_generation = '0;
        end
        1: begin
          req.handle_index = 8'($urandom_range(SLOTS, 255));
        end
        2: begin
          // A live slot named with one generation bit flipped.
          if (live_list.size() != 0) begin
            pick                  = live_list[$urandom_range(0, live_list.size() - 1)];
            req.handle_index      = 8'(pick);
            req.handle_generation = pool_gen[pick] ^ (16'd1 << $urandom_range(0, 15));
          end
        end
        3: begin
          // A dead slot named with the generation it last held.
          if (dead_list.size() != 0) begin
            pick                  = dead_list[$urandom_range(0, dead_list.size() - 1)];
            req.handle_index      = 8'(pick);
            req.handle_generation = pool_gen[pick];
          end
        end
        default: begin
        end
      endcase
    end
    return req;
  endfunction

  // Drops start for the requested idle time. The caller is always sitting on a rising edge.
  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Bursts of back-to-back items separated by gaps of random length. Gap
  // lengths vary so that requests arrive at every point of the busy window.
  task automatic pace_sender();
    if (burst_left == 0) begin
      idle_cycles($urandom_range(1, 12));
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
  endtask

  // Presents one item and holds it until the edge that accepts it. At that
  // edge the model is advanced and the expectation queued. Start is left
  // high so that the next item can follow with no gap.
  task automatic issue_request(input ghp_in_item_t req, input bit typed,
                               input ghp_out_item_t want, output ghp_out_item_t predicted);
    start   <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predicted = predict_pool(req);
    expected_results.push_back(typed ? want : predicted);
  endtask

  // Holds the sender off until every owed result has come back.
  task automatic wait_drain();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input ghp_out_item_t want,
                                 input ghp_out_item_t got);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("ERROR %s: expected ok=%0b status=%0d index=%0d gen=%h word=%h",
               what, want.ok, want.status, want.index_out, want.generation_out,
               want.payload_out);
      $display("      %s    got ok=%0b status=%0d index=%0d gen=%h word=%h",
               what, got.ok, got.status, got.index_out, got.generation_out, got.payload_out);
    end
  endtask

  // Every strobed result is matched against the oldest owed result. The
  // design cannot be stalled, so each strobe is taken at the edge that ends it.
  always @(posedge clk) begin : check_results
    ghp_out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unrequested result", '0, out_item);
      end else begin
        want = expected_results.pop_front();
        if (out_item.ok !== want.ok || out_item.status !== want.status ||
            out_item.index_out !== want.index_out ||
            out_item.generation_out !== want.generation_out ||
            out_item.payload_out !== want.payload_out) begin
          report_mismatch("result mismatch", want, out_item);
        end
      end
    end
  end

  // The run is abandoned if neither side moves an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_LIMIT) begin
      $display("generational_handle_pool_tb NOT OK");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin : stimulus
    ghp_out_item_t got;
    ghp_in_item_t  req;
    int            full_hits;
    int            n;
    int            s;

    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    for (s = 0; s < SLOTS; s++) begin
      pool_alive[s] = 1'b0;
      pool_gen[s]   = '0;
      pool_word[s]  = '0;
    end

    // Directed table. Hand-written results cover the fresh pool, the
    // malformed and stale rejections and the first creates; the rows in
    // between rely on the model.
    add_row(mk_req(MODE_LOOKUP, 0, 1, '0), 1, mk_res(1'b0, ST_STALE, 0, 0, '0));
    add_row(mk_req(MODE_UPDATE, 0, 0, '1), 1, mk_res(1'b0, ST_MALFORMED, 0, 0, '0));
    add_row(mk_req(MODE_DESTROY, SLOTS, 1, '0), 1, mk_res(1'b0, ST_MALFORMED, 0, 0, '0));
    add_row(mk_req(MODE_LOOKUP, 255, 16'hFFFF, '1), 1,
            mk_res(1'b0, ST_MALFORMED, 0, 0, '0));
    add_row(mk_req(MODE_CREATE, 255, 16'hFFFF, '1), 1, mk_res(1'b1, ST_OK, 0, 1, '0));
    add_row(mk_req(MODE_CREATE, 0, 0, '0), 1, mk_res(1'b1, ST_OK, 1, 1, '0));
    add_row(mk_req(MODE_LOOKUP, 0, 1, '0), 1, mk_res(1'b1, ST_OK, 0, 0, '1));
    add_row(mk_req(MODE_LOOKUP, 1, 1, '1), 1, mk_res(1'b1, ST_OK, 0, 0, '0));
    add_row(mk_req(MODE_LOOKUP, 0, 16'h8001, '0), 1, mk_res(1'b0, ST_STALE, 0, 0, '0));
    add_row(mk_req(MODE_LOOKUP, 0, 3, '0), 1, mk_res(1'b0, ST_STALE, 0, 0, '0));
    add_row(mk_req(MODE_UPDATE, 1, 1, 64'hA5A5_5A5A_0F0F_F0F0), 0, '0);
    add_row(mk_req(MODE_LOOKUP, 1, 1, '0), 0, '0);
    add_row(mk_req(MODE_DESTROY, 0, 1, '1), 0, '0);
    add_row(mk_req(MODE_LOOKUP, 0, 1, '0), 1, mk_res(1'b0, ST_STALE, 0, 0, '0));
    add_row(mk_req(MODE_DESTROY, 0, 1, '0), 1, mk_res(1'b0, ST_STALE, 0, 0, '0));
    add_row(mk_req(MODE_UPDATE, 0, 1, '1), 1, mk_res(1'b0, ST_STALE, 0, 0, '0));
    add_row(mk_req(MODE_CREATE, 0, 1, 64'h0123_4567_89AB_CDEF), 0, '0);
    add_row(mk_req(MODE_LOOKUP, 0, 1, '0), 0, '0);
    add_row(mk_req(MODE_LOOKUP, 0, 2, '0), 0, '0);
    add_row(mk_req(MODE_UPDATE, SLOTS - 1, 1, '1), 1, mk_res(1'b0, ST_STALE, 0, 0, '0));
    add_row(mk_req(MODE_DESTROY, 1, 1, '0), 0, '0);
    add_row(mk_req(MODE_CREATE, 7, 9, 64'hFEDC_BA98_7654_3210), 0, '0);
    add_row(mk_req(MODE_LOOKUP, 128, 1, '0), 1, mk_res(1'b0, ST_MALFORMED, 0, 0, '0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      pace_sender();
      issue_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want, got);
    end
    wait_drain();

    // Slot reuse: with slots zero and one held, every create lands on slot
    // two. Each create is followed by a destroy of the returned handle, so
    // the slot's generation climbs by one with every pair.
    for (n = 0; n < SWEEP_PAIRS; n++) begin
      issue_request(mk_req(MODE_CREATE, $urandom, $urandom, {$urandom, $urandom}), 0, '0, got);
      issue_request(mk_req(MODE_DESTROY, got.index_out, got.generation_out, {$urandom, $urandom}),
                    0, '0, got);
    end
    wait_drain();

    // Random part. The fill phase ends after a handful of pool-full replies,
    // and the drain phase ends once the pool is nearly empty.
    full_hits = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      pace_sender();
      req = random_request();
      issue_request(req, 0, '0, got);
      if (got.status == ST_FULL) full_hits++;
      if (filling && full_hits >= 6) begin
        filling = 1'b0;
      end else if (!filling && live_slots() <= 2) begin
        filling   = 1'b1;
        full_hits = 0;
      end
      // Every so often the sender stops until the design has caught up.
      if (n % 100 == 99) begin
        wait_drain();
      end
    end

    wait_drain();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("generational_handle_pool_tb OK");
    end else begin
      $display("generational_handle_pool_tb NOT OK");
    end
    $finish;
  end

endmodule
